// ===== sv/lfsa_pkg.sv =====
// shared constants and types of the lowest free slot allocator
package lfsa_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = 6;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // memory access issued by the scan controller
  typedef struct packed {
    logic  wr_en;
    slot_t wr_addr;
    time_t wr_data;
    slot_t rd_addr;
  } lfsa_mem_req_t;

  // allocation result handed to the output stage
  typedef struct packed {
    logic full;
    idx_t slot;
  } lfsa_res_t;

endpackage

// ===== sv/lfsa_if.sv =====
// request and result channel interfaces
interface lfsa_req_if;
  logic                 valid;
  logic                 ready;
  logic [lfsa_pkg::TIME_W-1:0] arrive_time;
  logic [lfsa_pkg::TIME_W-1:0] leave_time;

  modport source (output valid, output arrive_time, output leave_time, input ready);
  modport sink   (input valid, input arrive_time, input leave_time, output ready);
endinterface

interface lfsa_res_if;
  logic                       valid;
  logic                       ready;
  logic [lfsa_pkg::IDX_W-1:0] slot_index;
  logic                       full_res;

  modport source (output valid, output slot_index, output full_res, input ready);
  modport sink   (input valid, input slot_index, input full_res, output ready);
endinterface

// ===== sv/lfsa_slot_mem.sv =====
// busy-until time store, one write and one registered read port
module lfsa_slot_mem (
  input  logic                   clk,
  input  lfsa_pkg::lfsa_mem_req_t req,
  output lfsa_pkg::time_t        rd_data
);

  lfsa_pkg::time_t mem [lfsa_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

// ===== sv/lfsa_scan_ctrl.sv =====
// scan sequencer: walks the slot store and claims the lowest free slot
module lfsa_scan_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  lfsa_req_if.sink                req_ch,
  output lfsa_pkg::lfsa_mem_req_t mem_req,
  input  lfsa_pkg::time_t         rd_data,
  output logic                    res_valid,
  input  logic                    res_ready,
  output lfsa_pkg::lfsa_res_t     res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam lfsa_pkg::slot_t LAST_SLOT = lfsa_pkg::SLOT_W'(lfsa_pkg::NUM_SLOTS - 1);

  logic [1:0]      state;
  logic [1:0]      state_next;
  lfsa_pkg::slot_t chk;
  lfsa_pkg::time_t arrive;
  lfsa_pkg::time_t leave;
  logic [lfsa_pkg::NUM_SLOTS-1:0] written;

  logic free_hit;
  logic last_chk;

  assign last_chk = (chk == LAST_SLOT);
  // a slot never written counts as free, whatever the store holds
  assign free_hit = !written[chk] || (rd_data <= arrive);

  assign req_ch.ready = (state == ST_IDLE);
  assign res_valid    = (state == ST_DONE);

  always_comb begin
    mem_req.wr_en   = (state == ST_SCAN) && free_hit;
    mem_req.wr_addr = chk;
    mem_req.wr_data = leave;
    // read one slot ahead of the compare
    if (state == ST_SCAN && !last_chk) begin
      mem_req.rd_addr = chk + 1'b1;
    end else begin
      mem_req.rd_addr = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_ch.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (free_hit || last_chk) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      written <= '0;
      chk     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && req_ch.valid) begin
        chk <= '0;
      end else if (state == ST_SCAN && !free_hit && !last_chk) begin
        chk <= chk + 1'b1;
      end
      if (mem_req.wr_en) begin
        written[chk] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_ch.valid) begin
      arrive <= req_ch.arrive_time;
      leave  <= req_ch.leave_time;
    end
    if (state == ST_SCAN) begin
      if (free_hit) begin
        res.full <= 1'b0;
        res.slot <= lfsa_pkg::IDX_W'(chk);
      end else if (last_chk) begin
        res.full <= 1'b1;
        res.slot <= '0;
      end
    end
  end

endmodule

// ===== sv/lowest_free_slot_allocator_unit.sv =====
// top level of the lowest free slot allocator
//
// usage
//   req_ch carries one request beat: arrive_time and leave_time, arrivals
//   expected in nondecreasing order. res_ch returns one beat per request:
//   slot_index of the lowest slot whose busy-until time is at or below the
//   arrival time, or full_res high with slot_index zero when none is free.
// timing
//   the scan reads one slot per cycle from the synchronous store, one read
//   ahead of the compare. a new request is accepted only after the previous
//   result has been handed to the output register.
// reset
//   rst is synchronous, active high. per-slot written flags are cleared at
//   once, so every slot reads as free right after reset; no clearing pass.
// stall
//   the result sits in an output register; while res_ch is stalled the
//   scanner finishes the next request and holds its result until the
//   register frees up, and it takes no new request meanwhile
module lowest_free_slot_allocator_unit (
  input  logic       clk,
  input  logic       rst,
  lfsa_req_if.sink   req_ch,
  lfsa_res_if.source res_ch
);

  lfsa_pkg::lfsa_mem_req_t mem_req;
  lfsa_pkg::time_t         rd_data;
  logic                    res_valid;
  logic                    res_ready;
  lfsa_pkg::lfsa_res_t     res;

  // busy-until store
  lfsa_slot_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // scan sequencer with read-compare-write of one slot per cycle
  lfsa_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_ch    (req_ch),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: free when empty or its beat leaves this cycle
  logic out_valid;

  assign res_ready    = !out_valid || res_ch.ready;
  assign res_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_ch.slot_index <= res.slot;
      res_ch.full_res   <= res.full;
    end
  end

  // a new request is only taken while no result waits in the scanner
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_ch.valid && req_ch.ready) |-> !res_valid)
    else $error("request accepted while a result is pending");

  // claiming a slot raises a non-full scanner result in the next cycle
  a_write_then_res: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |=> (res_valid && !res.full))
    else $error("slot write without a matching result");

  // a blocked scanner result holds until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed while stalled");

  // a full result carries slot zero out of the output register
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.full) |=> (res_ch.valid && res_ch.slot_index == '0))
    else $error("full result with nonzero slot");

endmodule
